[hw/rtl/kbed_pkg.sv]
// Shared types and constants of the key debounce event detector.
`timescale 1ns / 1ps
package kbed_pkg;

  localparam int NUM_KEYS_DEF = 8;

  localparam int KEY_W   = 3;
  localparam int TICK_W  = 32;
  localparam int DEB_W   = 16;
  localparam int CLICK_W = 8;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK    = 2'd2;

  localparam logic [DEB_W-1:0]  DEB_RST   = 16'd20;
  localparam logic [TICK_W-1:0] LONG_RST  = 32'd1000;
  localparam logic [TICK_W-1:0] CLICK_RST = 32'd300;

  localparam logic [CLICK_W-1:0] CLICK_MAX = 8'hFF;

  // Phase bits: sampled level, debounced level, first-up gate
  localparam logic [2:0] LVL_BIT  = 3'h1;
  localparam logic [2:0] DEB_BIT  = 3'h2;
  localparam logic [2:0] GATE_BIT = 3'h4;
  localparam logic [2:0] PH_UP    = GATE_BIT | DEB_BIT | LVL_BIT;
  localparam logic [2:0] PH_GODN  = PH_UP ^ LVL_BIT;
  localparam logic [2:0] PH_DOWN  = PH_GODN ^ DEB_BIT;
  localparam logic [2:0] PH_GOUP  = PH_DOWN ^ LVL_BIT;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_CLICK   = 2'd2,
    EV_LONG    = 2'd3
  } kbed_kind_t;

  typedef struct packed {
    kbed_kind_t         kind;
    logic [KEY_W-1:0]   key;
    logic [CLICK_W-1:0] clicks;
    logic [TICK_W-1:0]  held;
    logic               last;
  } kbed_evt_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce;
    logic [TICK_W-1:0] long_press;
    logic [TICK_W-1:0] click_timeout;
  } kbed_cfg_t;

endpackage

[hw/rtl/kbed_key_unit.sv]
// Per-key state tables and the single-pass event decision for one request.
`timescale 1ns / 1ps
module kbed_key_unit #(
  parameter int NUM_KEYS = kbed_pkg::NUM_KEYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [kbed_pkg::KEY_W-1:0]  key,
  input  logic                        lvl,
  input  logic [kbed_pkg::TICK_W-1:0] now,
  input  kbed_pkg::kbed_cfg_t         cfg,
  output logic [1:0]                  evt_cnt,
  output kbed_pkg::kbed_evt_t         evt0,
  output kbed_pkg::kbed_evt_t         evt1
);
  import kbed_pkg::*;

  localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [2:0]         phase_r [NUM_KEYS];
  logic [CLICK_W-1:0] cc_r    [NUM_KEYS];
  logic [TICK_W-1:0]  lct_r   [NUM_KEYS];
  logic [TICK_W-1:0]  lpref_r [NUM_KEYS];
  logic [TICK_W-1:0]  chg_r   [NUM_KEYS];
  logic [TICK_W-1:0]  prior_r [NUM_KEYS];

  logic [KIDX_W-1:0]  kidx;
  logic               in_range, ignore;
  logic [2:0]         ph0, phase_nxt;
  logic [CLICK_W-1:0] cc, cc_nxt;
  logic [TICK_W-1:0]  lct, lpref, chg, prior;
  logic [TICK_W-1:0]  lct_nxt, lpref_nxt, chg_nxt, prior_nxt;
  logic [TICK_W-1:0]  held;
  logic               click_hit, second_hit;
  kbed_evt_t          click_ev, second_ev;
  logic               upd;

  assign kidx     = KIDX_W'(key);
  assign in_range = 32'(key) < NUM_KEYS;
  assign cc       = cc_r[kidx];
  assign lct      = lct_r[kidx];
  assign lpref    = lpref_r[kidx];
  assign chg      = chg_r[kidx];
  assign prior    = prior_r[kidx];

  always_comb begin
    ignore     = !in_range || (((phase_r[kidx] & GATE_BIT) == 3'h0) && !lvl);
    ph0        = ((phase_r[kidx] & GATE_BIT) != 3'h0) ? phase_r[kidx] : PH_UP;
    held       = now - lpref;
    click_hit  = (cfg.click_timeout != '0) && (cc != '0) &&
                 ((now - lct) >= cfg.click_timeout);
    cc_nxt     = click_hit ? '0 : cc;
    phase_nxt  = ph0;
    lct_nxt    = lct;
    lpref_nxt  = lpref;
    chg_nxt    = chg;
    prior_nxt  = prior;
    second_hit = 1'b0;
    second_ev  = '{kind: EV_PRESS, key: key, clicks: '0, held: '0, last: 1'b1};
    click_ev   = '{kind: EV_CLICK, key: key, clicks: cc, held: '0, last: 1'b0};

    if (lvl != ph0[0]) begin
      phase_nxt = ph0 ^ LVL_BIT;
      chg_nxt   = now;
    end else if (ph0 == PH_GODN) begin
      if ((now - chg) >= TICK_W'(cfg.debounce)) begin
        phase_nxt  = PH_DOWN;
        prior_nxt  = chg;
        lpref_nxt  = chg;
        second_hit = 1'b1;
      end
    end else if (ph0 == PH_DOWN) begin
      if ((cfg.long_press != '0) && (held >= cfg.long_press)) begin
        second_hit     = 1'b1;
        second_ev.kind = EV_LONG;
        second_ev.held = held;
        lpref_nxt      = lpref + cfg.long_press;
      end
    end else if (ph0 == PH_GOUP) begin
      if ((now - chg) >= TICK_W'(cfg.debounce)) begin
        if ((chg - prior) < cfg.click_timeout) begin
          if (cc_nxt != CLICK_MAX) begin
            cc_nxt = cc_nxt + 8'd1;
          end
          lct_nxt = chg;
        end
        phase_nxt      = PH_UP;
        prior_nxt      = chg;
        second_hit     = 1'b1;
        second_ev.kind = EV_RELEASE;
      end
    end

    // Click report goes first; the final result carries the last flag.
    evt1 = second_ev;
    if (ignore) begin
      evt_cnt = 2'd0;
      evt0    = second_ev;
    end else if (click_hit && second_hit) begin
      evt_cnt = 2'd2;
      evt0    = click_ev;
    end else if (click_hit) begin
      evt_cnt       = 2'd1;
      evt0          = click_ev;
      evt0.last     = 1'b1;
    end else if (second_hit) begin
      evt_cnt = 2'd1;
      evt0    = second_ev;
    end else begin
      evt_cnt = 2'd0;
      evt0    = second_ev;
    end
  end

  assign upd = fire && !ignore;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        phase_r[i] <= 3'h0;
        cc_r[i]    <= '0;
      end
    end else if (upd) begin
      phase_r[kidx] <= phase_nxt;
      cc_r[kidx]    <= cc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      lct_r[kidx]   <= lct_nxt;
      lpref_r[kidx] <= lpref_nxt;
      chg_r[kidx]   <= chg_nxt;
      prior_r[kidx] <= prior_nxt;
    end
  end

endmodule

[hw/rtl/kbed_evt_fifo.sv]
// Result queue: takes up to two events a cycle, hands out one.
`timescale 1ns / 1ps
module kbed_evt_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [1:0]          push_cnt,
  input  kbed_pkg::kbed_evt_t push0,
  input  kbed_pkg::kbed_evt_t push1,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output kbed_pkg::kbed_evt_t head
);
  import kbed_pkg::*;

  kbed_evt_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_r, rd_r;
  logic [FIFO_AW:0]     cnt_r;
  logic                 pop;
  logic [1:0]           n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign head      = mem_r[rd_r];
  // Room for two more after this cycle's pop.
  assign room      = (cnt_r - (FIFO_AW + 1)'(pop)) <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign n_push    = push ? push_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + FIFO_AW'(n_push);
      rd_r  <= rd_r + FIFO_AW'(pop);
      cnt_r <= cnt_r + (FIFO_AW + 1)'(n_push) - (FIFO_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_r + FIFO_AW'(1)] <= push1;
    end
  end

endmodule

[hw/rtl/key_debounce_event_detector_top.sv]
// Top level of the key debounce and event detector.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | key_index, pin_level, now_tick
//  out     | output    | out_valid/out_ready | event_kind, event_key, click_total,
//          |           |                     | held_ticks, last_event
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// One request per cycle is accepted while the input register is not stalled;
// it is held in the input register, where the key state is read, decided and
// written back in a single pass. Results pass from the input register into the
// result queue and show on the out ports from there; a request with two results
// takes the output port once for each, so the output side bounds the rate.
// The input register stalls when the four-entry result queue lacks room for two.
// Synchronous active-low reset clears key phases, click counts and the queue.
`timescale 1ns / 1ps
module key_debounce_event_detector_top #(
  parameter int NUM_KEYS = kbed_pkg::NUM_KEYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [kbed_pkg::KEY_W-1:0]     in_key_index,
  input  logic                           in_pin_level,
  input  logic [kbed_pkg::TICK_W-1:0]    in_now_tick,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_event_kind,
  output logic [kbed_pkg::KEY_W-1:0]     out_event_key,
  output logic [kbed_pkg::CLICK_W-1:0]   out_click_total,
  output logic [kbed_pkg::TICK_W-1:0]    out_held_ticks,
  output logic                           out_last_event,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kbed_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kbed_pkg::TICK_W-1:0]    cfg_data
);
  import kbed_pkg::*;

  kbed_cfg_t          cfg_r;
  logic               s1_valid_r;
  logic [KEY_W-1:0]   s1_key_r;
  logic               s1_lvl_r;
  logic [TICK_W-1:0]  s1_now_r;
  logic               room, fire;
  logic [1:0]         evt_cnt;
  kbed_evt_t          evt0, evt1, head;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid_r && room;
  assign in_ready  = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce      <= DEB_RST;
      cfg_r.long_press    <= LONG_RST;
      cfg_r.click_timeout <= CLICK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE: cfg_r.debounce      <= cfg_data[DEB_W-1:0];
        CFG_LONG:     cfg_r.long_press    <= cfg_data;
        CFG_CLICK:    cfg_r.click_timeout <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_key_r <= in_key_index;
      s1_lvl_r <= in_pin_level;
      s1_now_r <= in_now_tick;
    end
  end

  kbed_key_unit #(
    .NUM_KEYS(NUM_KEYS)
  ) u_key (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .key    (s1_key_r),
    .lvl    (s1_lvl_r),
    .now    (s1_now_r),
    .cfg    (cfg_r),
    .evt_cnt(evt_cnt),
    .evt0   (evt0),
    .evt1   (evt1)
  );

  kbed_evt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fire),
    .push_cnt (evt_cnt),
    .push0    (evt0),
    .push1    (evt1),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_event_kind  = head.kind;
  assign out_event_key   = head.key;
  assign out_click_total = head.clicks;
  assign out_held_ticks  = head.held;
  assign out_last_event  = head.last;

endmodule

[hw/rtl/kbed_checker.sv]
// Port-level checks for the key debounce event detector, bound to the top.
`timescale 1ns / 1ps
module kbed_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     out_event_kind,
  input logic [kbed_pkg::KEY_W-1:0]     out_event_key,
  input logic [kbed_pkg::CLICK_W-1:0]   out_click_total,
  input logic [kbed_pkg::TICK_W-1:0]    out_held_ticks,
  input logic                           out_last_event
);
  import kbed_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_event_kind) && $stable(out_event_key) &&
      $stable(out_click_total) && $stable(out_held_ticks) && $stable(out_last_event))
    else $error("stalled result changed");

  // A click report always carries at least one click.
  a_click_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_CLICK |-> out_click_total != '0)
    else $error("empty click report");

  // Press, release and long press come last in a request's results.
  a_second_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != EV_CLICK |-> out_last_event)
    else $error("non-click event not marked last");

  // Only a long press carries a held time.
  a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_PRESS || out_event_kind == EV_RELEASE ||
      out_event_kind == EV_CLICK) |-> out_held_ticks == '0)
    else $error("held ticks on a non-long-press event");

endmodule

bind key_debounce_event_detector_top kbed_checker u_kbed_checker (.*);

[dv/tb_top.sv]
// Self-checking bench for the key debounce event detector: scripted and random scan samples.
`timescale 1ns / 1ps
module tb_top;
  import kbed_pkg::*;

  localparam int          NKEYS         = NUM_KEYS_DEF;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          TRAIN_CLICKS  = 40;
  localparam logic [31:0] SPAN_CAP      = 32'h0010_0000;
  localparam logic [2:0]  TRAIN_KEY     = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              lvl;
    logic [TICK_W-1:0] tick;
  } scan_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KEY_W-1:0]     in_key_index = '0;
  logic                 in_pin_level = 1'b1;
  logic [TICK_W-1:0]    in_now_tick = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_event_kind;
  logic [KEY_W-1:0]     out_event_key;
  logic [CLICK_W-1:0]   out_click_total;
  logic [TICK_W-1:0]    out_held_ticks;
  logic                 out_last_event;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [TICK_W-1:0]    cfg_data = '0;

  key_debounce_event_detector_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key_index    (in_key_index),
    .in_pin_level    (in_pin_level),
    .in_now_tick     (in_now_tick),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_event_key   (out_event_key),
    .out_click_total (out_click_total),
    .out_held_ticks  (out_held_ticks),
    .out_last_event  (out_last_event),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of registers and per-key state
  logic [DEB_W-1:0]   deb_cfg;
  logic [TICK_W-1:0]  long_cfg;
  logic [TICK_W-1:0]  click_cfg;
  logic [2:0]         phase_of [NKEYS];
  logic [CLICK_W-1:0] clicks_of [NKEYS];
  logic [TICK_W-1:0]  click_at [NKEYS];
  logic [TICK_W-1:0]  hold_ref [NKEYS];
  logic [TICK_W-1:0]  level_at [NKEYS];
  logic [TICK_W-1:0]  prev_level_at [NKEYS];

  scan_sample_t scan_backlog [$];
  scan_sample_t next_sample;
  kbed_evt_t    events_due [$];
  kbed_evt_t    want;

  logic [TICK_W-1:0] tick_now = '0;
  logic idle_enable = 1'b1;
  int   send_gap = 0;
  int   recv_stall = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   samples_queued = 0;
  int   samples_taken = 0;
  int   events_seen = 0;
  int   reg_writes = 0;
  int   kind_seen [4] = '{0, 0, 0, 0};

  function automatic kbed_evt_t key_event(input kbed_kind_t kind, input logic [KEY_W-1:0] key,
                                          input logic [CLICK_W-1:0] clicks,
                                          input logic [TICK_W-1:0] held);
    kbed_evt_t e;
    e.kind   = kind;
    e.key    = key;
    e.clicks = clicks;
    e.held   = held;
    e.last   = 1'b0;
    return e;
  endfunction

  function automatic void predict_key_events(input logic [KEY_W-1:0] k, input logic lvl,
                                             input logic [TICK_W-1:0] now);
    kbed_evt_t found [$];
    logic [TICK_W-1:0] elapsed;
    if ((phase_of[k] & GATE_BIT) == 3'b0) begin
      // ignore a key held low since reset
      if (!lvl) return;
      phase_of[k] = PH_UP;
    end
    elapsed = now - click_at[k];
    if (click_cfg != 0 && clicks_of[k] != 0 && elapsed >= click_cfg) begin
      found.push_back(key_event(EV_CLICK, k, clicks_of[k], '0));
      clicks_of[k] = '0;
    end
    if (lvl != ((phase_of[k] & LVL_BIT) != 3'b0)) begin
      phase_of[k] = phase_of[k] ^ LVL_BIT;
      level_at[k] = now;
    end else begin
      case (phase_of[k])
        PH_GODN: begin
          elapsed = now - level_at[k];
          if (elapsed >= {16'd0, deb_cfg}) begin
            phase_of[k] = PH_DOWN;
            prev_level_at[k] = level_at[k];
            hold_ref[k] = level_at[k];
            found.push_back(key_event(EV_PRESS, k, '0, '0));
          end
        end
        PH_DOWN: begin
          elapsed = now - hold_ref[k];
          if (long_cfg != 0 && elapsed >= long_cfg) begin
            found.push_back(key_event(EV_LONG, k, '0, elapsed));
            // advance one interval only; the rest catches up later
            hold_ref[k] = hold_ref[k] + long_cfg;
          end
        end
        PH_GOUP: begin
          elapsed = now - level_at[k];
          if (elapsed >= {16'd0, deb_cfg}) begin
            elapsed = level_at[k] - prev_level_at[k];
            if (elapsed < click_cfg) begin
              if (clicks_of[k] != CLICK_MAX) clicks_of[k] = clicks_of[k] + 8'd1;
              click_at[k] = level_at[k];
            end
            phase_of[k] = PH_UP;
            prev_level_at[k] = level_at[k];
            found.push_back(key_event(EV_RELEASE, k, '0, '0));
          end
        end
        default: ;
      endcase
    end
    if (found.size() != 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) events_due.push_back(found[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  // Sender: hold the request until taken, then present the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_key_events(in_key_index, in_pin_level, in_now_tick);
        samples_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idle_enable && scan_backlog.size() != 0 && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (scan_backlog.size() != 0) begin
          next_sample = scan_backlog.pop_front();
          in_valid <= 1'b1;
          in_key_index <= next_sample.key;
          in_pin_level <= next_sample.lvl;
          in_now_tick <= next_sample.tick;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each event against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        events_seen++;
        kind_seen[out_event_kind]++;
        if (events_due.size() == 0) begin
          report_mismatch("event with none pending", 32'(out_event_kind), 32'hFFFF_FFFF);
        end else begin
          want = events_due.pop_front();
          if (out_event_kind !== want.kind)
            report_mismatch("event_kind", 32'(out_event_kind), 32'(want.kind));
          if (out_event_key !== want.key)
            report_mismatch("event_key", 32'(out_event_key), 32'(want.key));
          if (out_click_total !== want.clicks)
            report_mismatch("click_total", 32'(out_click_total), 32'(want.clicks));
          if (out_held_ticks !== want.held)
            report_mismatch("held_ticks", out_held_ticks, want.held);
          if (out_last_event !== want.last)
            report_mismatch("last_event", 32'(out_last_event), 32'(want.last));
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 11) == 0) begin
        recv_stall = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Register writes as the block sees them
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE: deb_cfg = cfg_data[DEB_W-1:0];
        CFG_LONG:     long_cfg = cfg_data;
        CFG_CLICK:    click_cfg = cfg_data;
        default: ;
      endcase
      reg_writes++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_sample(input logic [KEY_W-1:0] k, input logic lvl,
                              input logic [TICK_W-1:0] t);
    scan_sample_t s;
    s.key  = k;
    s.lvl  = lvl;
    s.tick = t;
    scan_backlog.push_back(s);
    samples_queued++;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_config(input logic [DEB_W-1:0] deb, input logic [TICK_W-1:0] lp,
                              input logic [TICK_W-1:0] ct);
    put_reg(CFG_DEBOUNCE, {16'd0, deb});
    put_reg(CFG_LONG, lp);
    put_reg(CFG_CLICK, ct);
    cfg_valid <= 1'b0;
  endtask

  // Wait until the sender's backlog is drained and every predicted event is back, then let the pipe empty
  task automatic wait_quiet();
    while (scan_backlog.size() != 0 || in_valid || events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TICK_W-1:0] bounce_step();
    return $urandom_range(0, deb_cfg >> 1);
  endfunction

  function automatic logic [TICK_W-1:0] settle_step();
    if (deb_cfg != 0 && $urandom_range(0, 4) == 0) return deb_cfg - 1;
    return deb_cfg + $urandom_range(0, 2);
  endfunction

  function automatic logic [TICK_W-1:0] hold_step();
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 2 * deb_cfg + 10);
      2, 3: begin
        if (long_cfg != 0 && long_cfg <= SPAN_CAP)
          return $urandom_range(long_cfg / 2, long_cfg + long_cfg / 2);
        return $urandom_range(0, 5000);
      end
      4: begin
        if (click_cfg != 0 && click_cfg <= SPAN_CAP)
          return $urandom_range(click_cfg / 2, click_cfg + click_cfg / 2);
        return $urandom_range(0, 5000);
      end
      default: return $urandom();
    endcase
  endfunction

  // One press and release of a key, with bounce, hold and an optional wait for the report
  task automatic add_episode(input logic [KEY_W-1:0] k);
    logic [TICK_W-1:0] t;
    logic [TICK_W-1:0] down_at;
    logic [TICK_W-1:0] up_at;
    int n;
    t = tick_now;
    if ($urandom_range(0, 3) != 0) begin
      queue_sample(k, 1'b1, t);
      t = t + $urandom_range(1, 50);
    end
    n = $urandom_range(0, 2);
    repeat (n) begin
      queue_sample(k, 1'b0, t);
      t = t + bounce_step();
      queue_sample(k, 1'b1, t);
      t = t + bounce_step();
    end
    down_at = t;
    queue_sample(k, 1'b0, t);
    t = t + settle_step();
    queue_sample(k, 1'b0, t);
    n = $urandom_range(0, 3);
    if (n != 0 && long_cfg != 0 && $urandom_range(0, 2) == 0) begin
      // land on the long press threshold or one tick short of it
      t = down_at + long_cfg - $urandom_range(0, 1);
      queue_sample(k, 1'b0, t);
      n--;
    end
    repeat (n) begin
      t = t + hold_step();
      queue_sample(k, 1'b0, t);
    end
    n = $urandom_range(0, 2);
    repeat (n) begin
      queue_sample(k, 1'b1, t);
      t = t + bounce_step();
      queue_sample(k, 1'b0, t);
      t = t + bounce_step();
    end
    up_at = t;
    queue_sample(k, 1'b1, t);
    t = t + settle_step();
    queue_sample(k, 1'b1, t);
    case ($urandom_range(0, 2))
      0: begin
        t = up_at + click_cfg - $urandom_range(0, 1);
        queue_sample(k, 1'b1, t);
      end
      1: begin
        t = t + click_cfg + $urandom_range(0, 3);
        queue_sample(k, 1'b1, t);
      end
      default: t = t + $urandom_range(1, 40);
    endcase
    tick_now = t;
  endtask

  task automatic add_noise();
    logic [TICK_W-1:0] t;
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) begin
        tick_now = tick_now + $urandom_range(0, 3 * deb_cfg + 5);
        t = tick_now;
      end else begin
        t = $urandom();
      end
      queue_sample(KEY_W'($urandom_range(0, NKEYS - 1)), 1'($urandom_range(0, 1)), t);
    end
  endtask

  task automatic random_phase(input int count);
    int stop;
    logic [KEY_W-1:0] k;
    stop = samples_queued + count;
    k = KEY_W'($urandom_range(0, NKEYS - 1));
    while (samples_queued < stop) begin
      if ($urandom_range(0, 4) == 0) begin
        add_noise();
      end else begin
        // stay on one key now and then so clicks can pile up
        if ($urandom_range(0, 1) == 0) k = KEY_W'($urandom_range(0, NKEYS - 1));
        add_episode(k);
      end
    end
  endtask

  // A run of quick clicks on one key so its count builds up
  task automatic add_click_train();
    logic [TICK_W-1:0] t;
    t = tick_now;
    repeat (3) begin
      queue_sample(TRAIN_KEY, 1'b1, t);
      t = t + 1;
    end
    repeat (TRAIN_CLICKS) begin
      queue_sample(TRAIN_KEY, 1'b0, t);
      queue_sample(TRAIN_KEY, 1'b0, t + 1);
      queue_sample(TRAIN_KEY, 1'b1, t + 2);
      queue_sample(TRAIN_KEY, 1'b1, t + 3);
      t = t + 4;
    end
    tick_now = t;
  endtask

  initial begin
    deb_cfg   = DEB_RST;
    long_cfg  = LONG_RST;
    click_cfg = CLICK_RST;
    for (int i = 0; i < NKEYS; i++) begin
      phase_of[i]      = 3'b0;
      clicks_of[i]     = '0;
      click_at[i]      = '0;
      hold_ref[i]      = '0;
      level_at[i]      = '0;
      prev_level_at[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: gate, bounce, press, long press with catch-up, click, report, wrap
    queue_sample(3'd7, 1'b0, 32'd0);
    queue_sample(3'd0, 1'b0, 32'd5);
    queue_sample(3'd0, 1'b1, 32'd10);
    queue_sample(3'd0, 1'b0, 32'd12);
    queue_sample(3'd0, 1'b1, 32'd15);
    queue_sample(3'd0, 1'b0, 32'd20);
    queue_sample(3'd0, 1'b0, 32'd39);
    queue_sample(3'd0, 1'b0, 32'd40);
    queue_sample(3'd0, 1'b0, 32'd1020);
    queue_sample(3'd0, 1'b0, 32'd3100);
    queue_sample(3'd0, 1'b0, 32'd3101);
    queue_sample(3'd0, 1'b1, 32'd3110);
    queue_sample(3'd0, 1'b1, 32'd3130);
    queue_sample(3'd7, 1'b1, 32'd3140);
    queue_sample(3'd7, 1'b0, 32'd3150);
    queue_sample(3'd7, 1'b0, 32'd3170);
    queue_sample(3'd7, 1'b1, 32'd3200);
    queue_sample(3'd7, 1'b1, 32'd3220);
    queue_sample(3'd7, 1'b1, 32'd3499);
    queue_sample(3'd7, 1'b0, 32'd3500);
    queue_sample(3'd3, 1'b1, 32'hFFFF_FFF0);
    queue_sample(3'd3, 1'b0, 32'hFFFF_FFFF);
    queue_sample(3'd3, 1'b0, 32'h0000_0013);
    queue_sample(3'd3, 1'b0, 32'h0000_03E7);
    tick_now = 32'h0000_0400;
    wait_quiet();

    random_phase(130);
    wait_quiet();

    write_config(16'd0, 32'd0, 32'd0);
    random_phase(80);
    wait_quiet();

    write_config(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    tick_now = 32'hFFFF_0000;
    random_phase(100);
    wait_quiet();

    write_config(16'd5, 32'd50, 32'd200);
    random_phase(130);
    wait_quiet();

    write_config(16'd0, 32'd0, 32'hFFFF_FFFF);
    add_click_train();
    wait_quiet();

    // the built-up count comes out on the next sample of that key
    write_config(16'($urandom_range(0, 60)), 32'($urandom_range(1, 3000)), 32'd1);
    queue_sample(TRAIN_KEY, 1'b1, tick_now + 1);
    tick_now = tick_now + 2;
    random_phase(80);
    wait_quiet();

    idle_enable = 1'b0;
    write_config(16'd3, 32'd40, 32'd100);
    random_phase(80);
    wait_quiet();
    repeat (10) @(posedge clk);

    $display("run covered %0d scan samples and %0d register writes across seven settings",
             samples_taken, reg_writes);
    $display("events checked %0d: press %0d, release %0d, click report %0d, long press %0d",
             events_seen, kind_seen[EV_PRESS], kind_seen[EV_RELEASE], kind_seen[EV_CLICK],
             kind_seen[EV_LONG]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
